// ----- rtl/rc_frame_deframer_checksum_assert.svh -----
// assertion macros used by the checker file
// clock and reset names follow the project port naming
`ifndef RC_FRAME_DEFRAMER_CHECKSUM_ASSERT_SVH
`define RC_FRAME_DEFRAMER_CHECKSUM_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define RCDC_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("rc deframer check failed");

// next-cycle implication, disabled while reset is low
`define RCDC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("rc deframer check failed");

`endif

// ----- rtl/rcdc_pkg.sv -----
// ----------------------------------------------------------------------------
// rcdc_pkg
// shared widths, status codes, register indexes and structs of the deframer
// ----------------------------------------------------------------------------
package rcdc_pkg;

    localparam int BYTE_W    = 8;
    localparam int WORD_W    = 16;
    localparam int CHAN_W    = 4;
    localparam int POS_W     = 6;
    localparam int CFG_IDX_W = 2;

    // all-ones word: checksum base and idle counter ceiling
    localparam logic [WORD_W-1:0] WORD_ONES = 16'hFFFF;

    // input item kinds
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER_FIRST  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER_SECOND = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LOST_TICKS    = 2'd2;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_CSUM = 2'd1,
        ST_HDR_ERR  = 2'd2,
        ST_LOST     = 2'd3
    } t_status;

    typedef struct packed {
        logic [BYTE_W-1:0] header_first;
        logic [BYTE_W-1:0] header_second;
        logic [WORD_W-1:0] lost_comm_ticks;
    } t_cfg;

    // command passed from the front to the back
    typedef struct packed {
        t_status status;
        logic    bank;
    } t_cmd;

    // channel store read request from the back
    typedef struct packed {
        logic              bank;
        logic [CHAN_W-1:0] idx;
    } t_rd_req;

endpackage

// ----- rtl/rc_frame_deframer_checksum.sv -----
// ----------------------------------------------------------------------------
// rc_frame_deframer_checksum
// byte-serial rc frame deframer with additive checksum and link loss report
// ----------------------------------------------------------------------------
// throughput: one input item per cycle while full is low; results leave at one per cycle while pop is held
// a result passes the command queue and then the output register before it reaches the output ports
// a closed frame gives NUM_CHANNELS results in channel order from the result walk
// full rises when the two-entry command queue is full, or when both channel banks
// hold unread frames and the frame position is inside the channel bytes
// reset: synchronous active low; clears framing, counters and queue, loads register defaults
// ----------------------------------------------------------------------------
module rc_frame_deframer_checksum
    import rcdc_pkg::*;
#(
    parameter int NUM_CHANNELS = 14
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 push,
    output logic                 full,
    input  logic                 i_opcode,
    input  logic [BYTE_W-1:0]    i_rx_byte,
    output logic                 empty,
    input  logic                 pop,
    output logic [1:0]           o_status,
    output logic [CHAN_W-1:0]    o_channel_index,
    output logic [WORD_W-1:0]    o_channel_value,
    output logic                 o_last,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [WORD_W-1:0]    i_cfg_data
);

    t_cfg          r_cfg;
    logic          cmd_push;
    t_cmd          cmd_in;
    logic          cmd_full;
    logic          cmd_valid;
    t_cmd          cmd_head;
    logic          cmd_pop;
    logic          release_bank;
    t_rd_req       rd_req;
    logic [WORD_W-1:0] rd_data;

    assign o_cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.header_first    <= 8'd32;
            r_cfg.header_second   <= 8'd64;
            r_cfg.lost_comm_ticks <= 16'd20;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_HEADER_FIRST:  r_cfg.header_first    <= i_cfg_data[BYTE_W-1:0];
                CFG_HEADER_SECOND: r_cfg.header_second   <= i_cfg_data[BYTE_W-1:0];
                CFG_LOST_TICKS:    r_cfg.lost_comm_ticks <= i_cfg_data;
                default:           r_cfg <= r_cfg;
            endcase
        end
    end

    // framing front
    rcdc_front #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_push     (push),
        .i_opcode   (i_opcode),
        .i_rx_byte  (i_rx_byte),
        .o_full     (full),
        .o_cmd_push (cmd_push),
        .o_cmd      (cmd_in),
        .i_cmd_full (cmd_full),
        .i_release  (release_bank),
        .i_rd       (rd_req),
        .o_rd_data  (rd_data)
    );

    // command queue
    rcdc_cmd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_cmd   (cmd_in),
        .o_full  (cmd_full),
        .i_pop   (cmd_pop),
        .o_valid (cmd_valid),
        .o_head  (cmd_head)
    );

    // result back end
    rcdc_back #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_head_valid    (cmd_valid),
        .i_head          (cmd_head),
        .o_head_pop      (cmd_pop),
        .o_release       (release_bank),
        .o_rd            (rd_req),
        .i_rd_data       (rd_data),
        .o_empty         (empty),
        .i_pop           (pop),
        .o_status        (o_status),
        .o_channel_index (o_channel_index),
        .o_channel_value (o_channel_value),
        .o_last          (o_last)
    );

endmodule

// ----- rtl/rcdc_cmd_queue.sv -----
// ----------------------------------------------------------------------------
// rcdc_cmd_queue
// two-entry command queue between the front and the back
// ----------------------------------------------------------------------------
module rcdc_cmd_queue
    import rcdc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_cmd o_head
);

    t_cmd       r_slot [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_head  = r_slot[r_rptr];

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wptr <= ~r_wptr;
            end
            if (i_pop) begin
                r_rptr <= ~r_rptr;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wptr] <= i_cmd;
        end
    end

endmodule

// ----- rtl/rcdc_front.sv -----
// ----------------------------------------------------------------------------
// rcdc_front
// byte framing, running checksum, channel capture and idle tick counting
// ----------------------------------------------------------------------------
module rcdc_front
    import rcdc_pkg::*;
#(
    parameter int NUM_CHANNELS = 14
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cfg              i_cfg,
    input  logic              i_push,
    input  logic              i_opcode,
    input  logic [BYTE_W-1:0] i_rx_byte,
    output logic              o_full,
    output logic              o_cmd_push,
    output t_cmd              o_cmd,
    input  logic              i_cmd_full,
    input  logic              i_release,
    input  t_rd_req           i_rd,
    output logic [WORD_W-1:0] o_rd_data
);

    localparam int CSUM_POS = 2 + 2 * NUM_CHANNELS;
    localparam int CH_W     = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    localparam logic [POS_W-1:0] POS_HUNT = POS_W'(0);
    localparam logic [POS_W-1:0] POS_HDR2 = POS_W'(1);
    localparam logic [POS_W-1:0] POS_DATA = POS_W'(2);
    localparam logic [POS_W-1:0] POS_CSUM = POS_W'(CSUM_POS);

    logic [POS_W-1:0]  r_pos,      n_pos;
    logic [WORD_W-1:0] r_sum,      n_sum;
    logic [BYTE_W-1:0] r_low,      n_low;
    logic [WORD_W-1:0] r_idle,     n_idle;
    logic              r_lost_rep, n_lost_rep;
    logic              r_wbank,    n_wbank;
    logic [1:0]        r_busy,     n_busy;
    logic [WORD_W-1:0] r_store [2][NUM_CHANNELS];

    logic              accept;
    logic              store_we;
    logic              frame_done;
    logic [POS_W-1:0]  rel;
    logic [CH_W-1:0]   wr_idx;
    logic [WORD_W-1:0] recv_word;
    logic [WORD_W-1:0] calc_word;
    logic [WORD_W-1:0] idle_inc;

    // command queue full, or both banks held by unread frames: stall before overwriting a channel word
    assign o_full = i_cmd_full ||
                    ((r_busy == 2'd2) && (r_pos >= POS_DATA) && (r_pos < POS_CSUM));
    assign accept = i_push && !o_full;

    assign rel       = r_pos - POS_DATA;
    assign wr_idx    = rel[CH_W:1];
    assign recv_word = {i_rx_byte, r_low};
    assign calc_word = WORD_ONES - r_sum;
    assign idle_inc  = (r_idle == WORD_ONES) ? r_idle : (r_idle + WORD_W'(1));

    assign o_rd_data = r_store[i_rd.bank][i_rd.idx[CH_W-1:0]];

    // per-item framing and tick handling
    always_comb begin
        n_pos      = r_pos;
        n_sum      = r_sum;
        n_low      = r_low;
        n_idle     = r_idle;
        n_lost_rep = r_lost_rep;
        n_wbank    = r_wbank;
        store_we   = 1'b0;
        frame_done = 1'b0;
        o_cmd_push = 1'b0;
        o_cmd      = '{status: ST_OK, bank: r_wbank};
        if (accept) begin
            if (i_opcode == OP_TICK) begin
                n_idle = idle_inc;
                if ((idle_inc >= i_cfg.lost_comm_ticks) && !r_lost_rep) begin
                    n_lost_rep   = 1'b1;
                    o_cmd_push   = 1'b1;
                    o_cmd.status = ST_LOST;
                end
            end else if (r_pos == POS_HUNT) begin
                if (i_rx_byte == i_cfg.header_first) begin
                    n_sum = WORD_W'(i_rx_byte);
                    n_pos = POS_HDR2;
                end
            end else if (r_pos == POS_HDR2) begin
                if (i_rx_byte == i_cfg.header_second) begin
                    n_sum = r_sum + WORD_W'(i_rx_byte);
                    n_pos = POS_DATA;
                end else begin
                    n_pos        = POS_HUNT;
                    o_cmd_push   = 1'b1;
                    o_cmd.status = ST_HDR_ERR;
                end
            end else if (r_pos < POS_CSUM) begin
                n_sum = r_sum + WORD_W'(i_rx_byte);
                if (!rel[0]) begin
                    n_low = i_rx_byte;
                end else begin
                    store_we = 1'b1;
                end
                n_pos = r_pos + POS_W'(1);
            end else if (r_pos == POS_CSUM) begin
                n_low = i_rx_byte;
                n_pos = r_pos + POS_W'(1);
            end else begin
                // checksum high byte closes the frame
                frame_done   = 1'b1;
                o_cmd_push   = 1'b1;
                o_cmd.status = (calc_word == recv_word) ? ST_OK : ST_BAD_CSUM;
                n_wbank      = ~r_wbank;
                n_pos        = POS_HUNT;
                n_sum        = '0;
                n_idle       = '0;
                n_lost_rep   = 1'b0;
            end
        end
    end

    // count of banks waiting on the back
    always_comb begin
        case ({frame_done, i_release})
            2'b10:   n_busy = r_busy + 2'd1;
            2'b01:   n_busy = r_busy - 2'd1;
            default: n_busy = r_busy;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= POS_HUNT;
            r_sum      <= '0;
            r_low      <= '0;
            r_idle     <= '0;
            r_lost_rep <= 1'b0;
            r_wbank    <= 1'b0;
            r_busy     <= 2'd0;
        end else begin
            r_pos      <= n_pos;
            r_sum      <= n_sum;
            r_low      <= n_low;
            r_idle     <= n_idle;
            r_lost_rep <= n_lost_rep;
            r_wbank    <= n_wbank;
            r_busy     <= n_busy;
        end
    end

    // channel word banks
    always_ff @(posedge i_clk) begin
        if (store_we) begin
            r_store[r_wbank][wr_idx] <= recv_word;
        end
    end

endmodule

// ----- rtl/rcdc_back.sv -----
// ----------------------------------------------------------------------------
// rcdc_back
// expands queued commands into result transactions through an output register
// ----------------------------------------------------------------------------
module rcdc_back
    import rcdc_pkg::*;
#(
    parameter int NUM_CHANNELS = 14
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_head_valid,
    input  t_cmd              i_head,
    output logic              o_head_pop,
    output logic              o_release,
    output t_rd_req           o_rd,
    input  logic [WORD_W-1:0] i_rd_data,
    output logic              o_empty,
    input  logic              i_pop,
    output logic [1:0]        o_status,
    output logic [CHAN_W-1:0] o_channel_index,
    output logic [WORD_W-1:0] o_channel_value,
    output logic              o_last
);

    localparam logic [CHAN_W-1:0] LAST_CH = CHAN_W'(NUM_CHANNELS - 1);

    logic [CHAN_W-1:0] r_k;
    logic              r_out_valid;
    t_status           r_status;
    logic [CHAN_W-1:0] r_idx;
    logic [WORD_W-1:0] r_value;
    logic              r_last;

    logic load;
    logic is_frame;
    logic res_last;

    assign is_frame   = (i_head.status == ST_OK) || (i_head.status == ST_BAD_CSUM);
    assign res_last   = !is_frame || (r_k == LAST_CH);
    assign load       = i_head_valid && (!r_out_valid || i_pop);
    assign o_head_pop = load && res_last;
    assign o_release  = o_head_pop && is_frame;

    assign o_rd = '{bank: i_head.bank, idx: r_k};

    assign o_empty         = !r_out_valid;
    assign o_status        = r_status;
    assign o_channel_index = r_idx;
    assign o_channel_value = r_value;
    assign o_last          = r_last;

    // channel walk and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_k         <= res_last ? '0 : (r_k + CHAN_W'(1));
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_status <= i_head.status;
            r_idx    <= is_frame ? r_k : '0;
            r_value  <= is_frame ? i_rd_data : '0;
            r_last   <= res_last;
        end
    end

endmodule

// ----- rtl/rcdc_checker.sv -----
// ----------------------------------------------------------------------------
// rcdc_checker
// port-level checks on the result side of the deframer, bound to the top level
// ----------------------------------------------------------------------------
`include "rc_frame_deframer_checksum_assert.svh"

module rcdc_checker
    import rcdc_pkg::*;
#(
    parameter int NUM_CHANNELS = 14
) (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 empty,
    input logic                 pop,
    input logic [1:0]           o_status,
    input logic [CHAN_W-1:0]    o_channel_index,
    input logic [WORD_W-1:0]    o_channel_value,
    input logic                 o_last
);

    localparam logic [CHAN_W-1:0] LAST_CH = CHAN_W'(NUM_CHANNELS - 1);

    logic                     res_wait;
    logic [2+CHAN_W+WORD_W:0] res_payload;
    logic                     res_no_chan;
    logic                     no_chan_ok;
    logic                     res_step;
    logic [CHAN_W-1:0]        r_prev_idx;
    logic                     idx_up;
    logic                     res_frame_end;

    assign res_wait      = !empty && !pop;
    assign res_payload   = {o_status, o_channel_index, o_channel_value, o_last};
    assign res_no_chan   = !empty && ((o_status == ST_HDR_ERR) || (o_status == ST_LOST));
    assign no_chan_ok    = (o_channel_index == '0) && (o_channel_value == '0) && o_last;
    assign res_step      = !empty && pop && !o_last;
    assign idx_up        = (o_channel_index == (r_prev_idx + CHAN_W'(1)));
    assign res_frame_end = !empty && o_last &&
                           ((o_status == ST_OK) || (o_status == ST_BAD_CSUM));

    // channel number seen on the previous edge
    always_ff @(posedge i_clk) begin
        r_prev_idx <= o_channel_index;
    end

    // a waiting result holds until taken
    `RCDC_ASSERT_NEXT(a_result_hold, res_wait, !empty && $stable(res_payload))

    // header error and link loss carry no channel and close their transaction group
    `RCDC_ASSERT_SAME(a_no_channel, res_no_chan, no_chan_ok)

    // frame results follow each other without gaps and with rising channel numbers
    `RCDC_ASSERT_NEXT(a_channel_step, res_step, !empty && $stable(o_status) && idx_up)

    // the final frame result is the highest channel
    `RCDC_ASSERT_SAME(a_frame_last, res_frame_end, o_channel_index == LAST_CH)

endmodule

bind rc_frame_deframer_checksum rcdc_checker #(
    .NUM_CHANNELS (NUM_CHANNELS)
) u_rcdc_checker (.*);

// ----- verif/rc_frame_deframer_checksum_test.sv -----
// ----------------------------------------------------------------------------
// rc_frame_deframer_checksum_test
// self-checking testbench for the byte-serial rc frame deframer: a cycle-free
// software copy of the deframer predicts every result, which is compared
// field by field against the result queue while both sides idle at random
// ----------------------------------------------------------------------------
module rc_frame_deframer_checksum_test;
    timeunit 1ns;
    timeprecision 1ps;

    import rcdc_pkg::*;

    localparam int NUM_CH         = 14;
    localparam int CSUM_POS       = 2 + 2 * NUM_CH;
    localparam int FRAME_BYTES    = CSUM_POS + 2;
    localparam int SETTLE_CYCLES  = 8;
    localparam int RX_HOLD_CYCLES = 400;
    localparam int WATCHDOG_LIMIT = 3000;

    typedef struct packed {
        t_status             status;
        logic [CHAN_W-1:0]   idx;
        logic [WORD_W-1:0]   value;
        logic                last;
    } t_result;

    logic                 i_clk;
    logic                 i_rst_n     = 1'b0;
    logic                 push        = 1'b0;
    logic                 full;
    logic                 i_opcode    = OP_BYTE;
    logic [BYTE_W-1:0]    i_rx_byte   = '0;
    logic                 empty;
    logic                 pop         = 1'b0;
    logic [1:0]           o_status;
    logic [CHAN_W-1:0]    o_channel_index;
    logic [WORD_W-1:0]    o_channel_value;
    logic                 o_last;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [WORD_W-1:0]    i_cfg_data  = '0;

    // software copy of the deframer state and its registers
    logic [POS_W-1:0]  frame_pos;
    logic [WORD_W-1:0] run_sum;
    logic [BYTE_W-1:0] low_hold;
    logic [WORD_W-1:0] chan_words [NUM_CH];
    logic [WORD_W-1:0] idle_ticks;
    logic              loss_flag;
    logic [BYTE_W-1:0] hdr_first_cfg;
    logic [BYTE_W-1:0] hdr_second_cfg;
    logic [WORD_W-1:0] lost_ticks_cfg;

    // results still owed by the block, oldest first
    t_result deframed_q [$];

    bit steady      = 1'b0;
    bit rx_hold_req = 1'b0;
    int err_count   = 0;
    int items_sent  = 0;
    int frames_sent = 0;
    int stall_cycles = 0;
    int cfg_writes  = 0;
    int n_ok        = 0;
    int n_bad       = 0;
    int n_hdr       = 0;
    int n_lost      = 0;

    rc_frame_deframer_checksum #(
        .NUM_CHANNELS(NUM_CH)
    ) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_opcode       (i_opcode),
        .i_rx_byte      (i_rx_byte),
        .empty          (empty),
        .pop            (pop),
        .o_status       (o_status),
        .o_channel_index(o_channel_index),
        .o_channel_value(o_channel_value),
        .o_last         (o_last),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    task automatic report_error(input string msg);
        $display("ERROR at %0t: %s", $time, msg);
        err_count++;
    endtask

    function automatic t_result make_result(input t_status st, input logic [CHAN_W-1:0] idx,
                                            input logic [WORD_W-1:0] val, input logic last);
        t_result r;
        r.status = st;
        r.idx    = idx;
        r.value  = val;
        r.last   = last;
        return r;
    endfunction

    // mostly short gaps, a few long ones, none during steady stretches
    function automatic int idle_gap();
        int r;
        if (steady) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // advance the deframer copy by one accepted item and queue its results
    task automatic deframe_item(input logic op, input logic [BYTE_W-1:0] b);
        int                rel;
        t_status           st;
        logic [WORD_W-1:0] recv;
        logic [WORD_W-1:0] calc;
        if (op == OP_TICK) begin
            if (idle_ticks != WORD_ONES) idle_ticks = idle_ticks + 1'b1;
            if (idle_ticks >= lost_ticks_cfg && !loss_flag) begin
                loss_flag = 1'b1;
                deframed_q.push_back(make_result(ST_LOST, '0, '0, 1'b1));
            end
        end else if (frame_pos == 0) begin
            if (b == hdr_first_cfg) begin
                run_sum   = WORD_W'(b);
                frame_pos = POS_W'(1);
            end
        end else if (frame_pos == 1) begin
            if (b == hdr_second_cfg) begin
                run_sum   = run_sum + WORD_W'(b);
                frame_pos = POS_W'(2);
            end else begin
                // wrong second header: byte dropped, back to hunting
                frame_pos = '0;
                deframed_q.push_back(make_result(ST_HDR_ERR, '0, '0, 1'b1));
            end
        end else if (frame_pos < CSUM_POS) begin
            rel     = int'(frame_pos) - 2;
            run_sum = run_sum + WORD_W'(b);
            if (rel % 2 == 0) begin
                low_hold = b;
            end else begin
                chan_words[rel / 2] = {b, low_hold};
            end
            frame_pos = frame_pos + 1'b1;
        end else if (frame_pos == CSUM_POS) begin
            low_hold  = b;
            frame_pos = frame_pos + 1'b1;
        end else begin
            // frame end: one result per channel, all with the checksum verdict
            recv = {b, low_hold};
            calc = WORD_ONES - run_sum;
            st   = (calc == recv) ? ST_OK : ST_BAD_CSUM;
            for (int k = 0; k < NUM_CH; k++) begin
                deframed_q.push_back(make_result(st, CHAN_W'(k), chan_words[k],
                                                 k == NUM_CH - 1));
            end
            frame_pos  = '0;
            run_sum    = '0;
            idle_ticks = '0;
            loss_flag  = 1'b0;
        end
    endtask

    // offer one item after a random gap and wait until it is taken
    task automatic send_item(input logic op, input logic [BYTE_W-1:0] b);
        int gap;
        gap = idle_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        push      <= 1'b1;
        i_opcode  <= op;
        i_rx_byte <= b;
        @(posedge i_clk);
        while (full) begin
            stall_cycles++;
            @(posedge i_clk);
        end
        deframe_item(op, b);
        items_sent++;
    endtask

    // write one register through the configuration channel
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_HEADER_FIRST:  hdr_first_cfg  = data[BYTE_W-1:0];
            CFG_HEADER_SECOND: hdr_second_cfg = data[BYTE_W-1:0];
            CFG_LOST_TICKS:    lost_ticks_cfg = data;
            default: ;
        endcase
        cfg_writes++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // stop offering, wait for every owed result, then let silent items drain
    task automatic settle_idle();
        @(negedge i_clk);
        push <= 1'b0;
        while (deframed_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // one frame with the current headers, optional bad checksum and ticks mixed in
    task automatic send_frame(input bit extremes, input bit bad_csum, input int tick_pct);
        logic [BYTE_W-1:0] fb [FRAME_BYTES];
        logic [WORD_W-1:0] word;
        logic [WORD_W-1:0] sum;
        int                r;
        fb[0] = hdr_first_cfg;
        fb[1] = hdr_second_cfg;
        for (int k = 0; k < NUM_CH; k++) begin
            if (extremes) begin
                case (k % 3)
                    0:       word = 16'h0000;
                    1:       word = 16'hFFFF;
                    default: word = 16'h8001;
                endcase
            end else begin
                r = $urandom_range(0, 7);
                if (r == 0)      word = 16'h0000;
                else if (r == 1) word = 16'hFFFF;
                else             word = WORD_W'($urandom);
            end
            fb[2 + 2 * k] = word[7:0];
            fb[3 + 2 * k] = word[15:8];
        end
        sum = '0;
        for (int i = 0; i < CSUM_POS; i++) sum = sum + WORD_W'(fb[i]);
        word = WORD_ONES - sum;
        if (bad_csum) word = word ^ WORD_W'($urandom_range(1, 65535));
        fb[CSUM_POS]     = word[7:0];
        fb[CSUM_POS + 1] = word[15:8];
        for (int i = 0; i < FRAME_BYTES; i++) begin
            if (i > 0 && $urandom_range(0, 99) < tick_pct) send_item(OP_TICK, 8'($urandom));
            send_item(OP_BYTE, fb[i]);
        end
        frames_sent++;
    endtask

    // byte extremes while hunting, wrong second header, repeated first header
    task automatic test_hunt_and_header_errors();
        send_item(OP_BYTE, 8'h00);
        send_item(OP_BYTE, 8'hFF);
        send_item(OP_BYTE, hdr_first_cfg);
        send_item(OP_BYTE, 8'h00);
        // a second first header is a header error, not a fresh start
        send_item(OP_BYTE, hdr_first_cfg);
        send_item(OP_BYTE, hdr_first_cfg);
        send_item(OP_BYTE, hdr_second_cfg);
        settle_idle();
    endtask

    // timeout reported once, cleared by a frame, zero timeout reports at once
    task automatic test_lost_link();
        write_reg(CFG_LOST_TICKS, 16'd3);
        repeat (4) send_item(OP_TICK, 8'($urandom));
        send_frame(1'b1, 1'b0, 10);
        settle_idle();
        write_reg(CFG_LOST_TICKS, 16'd0);
        send_item(OP_TICK, 8'hFF);
        send_item(OP_TICK, 8'h00);
        settle_idle();
    endtask

    // random traffic under one register setting, mostly well-formed frames
    task automatic test_random_frames(input logic [BYTE_W-1:0] hf, input logic [BYTE_W-1:0] hs,
                                      input logic [WORD_W-1:0] lost, input int n_items);
        int                stop_at;
        int                kind;
        logic [BYTE_W-1:0] b;
        settle_idle();
        // upper data bits are junk for the byte-wide registers
        write_reg(CFG_HEADER_FIRST, {8'($urandom), hf});
        write_reg(CFG_HEADER_SECOND, {8'($urandom), hs});
        write_reg(CFG_LOST_TICKS, lost);
        stop_at = items_sent + n_items;
        while (items_sent < stop_at) begin
            steady = ($urandom_range(0, 5) == 0);
            kind   = $urandom_range(0, 99);
            if (kind < 65) begin
                send_frame(1'b0, $urandom_range(0, 3) == 0, 4);
            end else if (kind < 75) begin
                b = 8'($urandom);
                if (b == hdr_second_cfg) b = ~b;
                send_item(OP_BYTE, hdr_first_cfg);
                send_item(OP_BYTE, b);
            end else if (kind < 84) begin
                repeat ($urandom_range(1, 4)) send_item(OP_BYTE, 8'($urandom));
            end else if (kind < 90) begin
                // truncated frame, the rest of the stream gets absorbed
                send_item(OP_BYTE, hdr_first_cfg);
                send_item(OP_BYTE, hdr_second_cfg);
                repeat ($urandom_range(1, 29)) send_item(OP_BYTE, 8'($urandom));
            end else begin
                repeat ($urandom_range(1, 6)) send_item(OP_TICK, 8'($urandom));
            end
        end
        steady = 1'b0;
    endtask

    // receiver holds off while frames keep coming, so the input must stall
    task automatic test_output_backpressure();
        settle_idle();
        rx_hold_req = 1'b1;
        steady      = 1'b1;
        repeat (3) send_frame(1'b0, 1'b0, 0);
        steady = 1'b0;
        @(negedge i_clk);
        push <= 1'b0;
        while (rx_hold_req) @(posedge i_clk);
        settle_idle();
    endtask

    // result side: random pop gaps, plus one long hold-off on request
    initial begin : result_drain
        int stall_left;
        stall_left = 0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_req) begin
                pop <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(negedge i_clk);
                rx_hold_req = 1'b0;
            end else if (stall_left > 0) begin
                pop <= 1'b0;
                stall_left--;
            end else begin
                pop <= 1'b1;
                stall_left = idle_gap();
            end
        end
    end

    // compare each popped result with the oldest owed one
    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && pop && !empty) begin
            case (o_status)
                ST_OK:       n_ok++;
                ST_BAD_CSUM: n_bad++;
                ST_HDR_ERR:  n_hdr++;
                default:     n_lost++;
            endcase
            if (deframed_q.size() == 0) begin
                report_error($sformatf("unexpected result status %0d index %0d value %h",
                                       o_status, o_channel_index, o_channel_value));
            end else begin
                want = deframed_q.pop_front();
                if (o_status !== want.status)
                    report_error($sformatf("status expected %0d got %0d",
                                           want.status, o_status));
                if (o_channel_index !== want.idx)
                    report_error($sformatf("channel_index expected %0d got %0d",
                                           want.idx, o_channel_index));
                if (o_channel_value !== want.value)
                    report_error($sformatf("channel_value expected %h got %h",
                                           want.value, o_channel_value));
                if (o_last !== want.last)
                    report_error($sformatf("last expected %0b got %0b", want.last, o_last));
            end
        end
    end

    // watchdog on cycles without any transaction
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((push && !full) || (pop && !empty) || (i_cfg_valid && o_cfg_ready)) quiet = 0;
            else quiet++;
        end
        $display("watchdog: no transaction for %0d cycles, %0d results still owed",
                 WATCHDOG_LIMIT, deframed_q.size());
        $display("TEST FAILED");
        $finish;
    end

    // test sequence
    initial begin : test_sequence
        frame_pos      = '0;
        run_sum        = '0;
        low_hold       = '0;
        idle_ticks     = '0;
        loss_flag      = 1'b0;
        hdr_first_cfg  = 8'd32;
        hdr_second_cfg = 8'd64;
        lost_ticks_cfg = 16'd20;
        for (int k = 0; k < NUM_CH; k++) chan_words[k] = '0;

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_hunt_and_header_errors();
        test_lost_link();
        test_random_frames(8'hFF, 8'h00, 16'd1, 40);
        test_random_frames(8'h00, 8'hFF, 16'hFFFF, 40);
        test_random_frames(8'($urandom), 8'($urandom), 16'($urandom_range(2, 40)), 35);
        test_output_backpressure();
        settle_idle();

        $display("covered %0d items in %0d built frames under %0d register writes",
                 items_sent, frames_sent, cfg_writes);
        $display("results: %0d ok, %0d bad checksum, %0d header error, %0d lost link; %0d %s",
                 n_ok, n_bad, n_hdr, n_lost, stall_cycles, "input stall cycles");
        if (err_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
